// ----- sv/rfsp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rfsp_pkg
// Shared types and constants for the RGB frame store with subpixel plotting.
// ---------------------------------------------------------------------------
package rfsp_pkg;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_SPLAT = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_SHIFT = 3'd4;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    typedef enum logic [2:0] {
        KIND_ERR   = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_READ  = 3'd2,
        KIND_SPLAT = 3'd3,
        KIND_CLEAR = 3'd4,
        KIND_SHIFT = 3'd5,
        KIND_NOP   = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [5:0] pos_x;
        logic [5:0] pos_y;
        logic [7:0] frac_x;
        logic [7:0] frac_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [5:0] amount;
        logic [1:0] dir;
    } cmd_t;

endpackage
`default_nettype wire

// ----- sv/rfsp_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rfsp_front
// Accepts commands, checks them against the window and queues them (2 deep).
// ---------------------------------------------------------------------------
module rfsp_front
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [2:0]   op,
    input  wire logic [5:0]   pos_x,
    input  wire logic [5:0]   pos_y,
    input  wire logic [7:0]   frac_x,
    input  wire logic [7:0]   frac_y,
    input  wire logic [7:0]   red_in,
    input  wire logic [7:0]   green_in,
    input  wire logic [7:0]   blue_in,
    input  wire logic [5:0]   shift_amount,
    input  wire logic [1:0]   shift_dir,
    input  wire logic [10:0]  eff_w,
    input  wire logic [10:0]  eff_h,
    output logic              cmd_valid,
    output rfsp_pkg::cmd_t    cmd,
    input  wire logic         cmd_take
);
    import rfsp_pkg::*;

    cmd_t       q_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    kind_t      kind;
    logic       inwin;
    logic       do_push;
    logic [10:0] amt;

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign inwin   = ({5'd0, pos_x} < eff_w) && ({5'd0, pos_y} < eff_h);
    assign amt     = {5'd0, shift_amount};

    always_comb
    begin
        kind = KIND_ERR;
        unique case (op)
            OP_WRITE: kind = inwin ? KIND_WRITE : KIND_ERR;
            OP_READ:  kind = inwin ? KIND_READ : KIND_ERR;
            OP_SPLAT: kind = KIND_SPLAT;
            OP_CLEAR: kind = KIND_CLEAR;
            OP_SHIFT:
            begin
                if (shift_amount == 6'd0)
                    kind = KIND_ERR;
                else if (shift_dir == DIR_LEFT || shift_dir == DIR_RIGHT)
                    kind = (amt < eff_w) ? KIND_SHIFT : KIND_NOP;
                else
                    kind = (amt < eff_h) ? KIND_SHIFT : KIND_NOP;
            end
            default:  kind = KIND_ERR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= '{kind, pos_x, pos_y, frac_x, frac_y, red_in, green_in,
                                   blue_in, shift_amount, shift_dir};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (cmd_take)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, cmd_take};
        end
    end

    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !cmd_take) |=> full) else $error("full dropped without take");

endmodule
`default_nettype wire

// ----- sv/rfsp_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rfsp_back
// Executes commands on the pixel memory and queues results (2 deep).
// ---------------------------------------------------------------------------
module rfsp_back
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [10:0] eff_w,
    input  wire logic [10:0] eff_h,
    input  wire logic        cmd_valid,
    input  rfsp_pkg::cmd_t   cmd,
    output logic             cmd_take,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic             status
);
    import rfsp_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_C = AW'(0) + (AW+1)'(DEPTH);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WGT   = 7'b0000100,
        S_RD    = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_WR    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;

    state_t      state_reg, state_next;
    cmd_t        c_reg;
    logic [AW:0] clr_reg;
    logic [1:0]  nb_reg;
    logic [10:0] x_reg, y_reg;
    logic [7:0]  wt_reg [4];
    logic [15:0] pr_reg, pg_reg, pb_reg;
    logic [23:0] res_rgb_reg;
    logic        res_st_reg;

    // result queue
    logic [24:0] rq_reg [2];
    logic        rq_rd_reg, rq_wr_reg;
    logic [1:0]  rq_cnt_reg;
    logic        res_push;

    logic        clearing;
    logic [AW-1:0] a_addr;
    logic        mem_we;
    logic [23:0] mem_wd;
    logic [10:0] src_x, src_y;
    logic [10:0] amt;
    logic        last_x, last_y;
    logic [10:0] x_first;
    logic [7:0]  wsel;
    logic [8:0]  sr, sg, sb;

    function automatic logic [7:0] wu(input logic [7:0] a, input logic [7:0] b);
        logic [16:0] t;
        t = {1'b0, 16'(a) * 16'(b)} + {9'd0, a} + {9'd0, b};
        return t[15:8];
    endfunction

    assign amt = {5'd0, c_reg.amount};

    // first column of a shift row, and per-step source
    always_comb
    begin
        x_first = 11'd0;
        if (c_reg.dir == DIR_RIGHT)
            x_first = eff_w - 11'd1;
        src_x = x_reg;
        src_y = y_reg;
        last_x = 1'b0;
        last_y = 1'b0;
        unique case (c_reg.dir)
            DIR_LEFT:
            begin
                src_x  = x_reg + amt;
                last_x = (x_reg + amt + 11'd1 >= eff_w);
                last_y = (y_reg + 11'd1 >= eff_h);
            end
            DIR_RIGHT:
            begin
                src_x  = x_reg - amt;
                last_x = (x_reg == amt);
                last_y = (y_reg + 11'd1 >= eff_h);
            end
            DIR_DOWN:
            begin
                src_y  = y_reg - amt;
                last_x = (x_reg + 11'd1 >= eff_w);
                last_y = (y_reg == amt);
            end
            default:
            begin
                src_y  = y_reg + amt;
                last_x = (x_reg + 11'd1 >= eff_w);
                last_y = (y_reg + amt + 11'd1 >= eff_h);
            end
        endcase
    end

    assign clearing = (state_reg == S_INIT);

    always_comb
    begin
        wsel = wt_reg[nb_reg];
        sr = {1'b0, rdata_reg[23:16]} + {1'b0, pr_reg[15:8]};
        sg = {1'b0, rdata_reg[15:8]}  + {1'b0, pg_reg[15:8]};
        sb = {1'b0, rdata_reg[7:0]}   + {1'b0, pb_reg[15:8]};
        a_addr = AW'(y_reg[YW-1:0] * MAX_WIDTH) + AW'(x_reg[XW-1:0]);
        mem_we = 1'b0;
        mem_wd = rdata_reg;
        if (clearing)
        begin
            a_addr = clr_reg[AW-1:0];
            mem_we = 1'b1;
            mem_wd = 24'd0;
        end
        else if (state_reg == S_RD && c_reg.kind == KIND_SHIFT)
            a_addr = AW'(src_y[YW-1:0] * MAX_WIDTH) + AW'(src_x[XW-1:0]);
        else if (state_reg == S_WR)
        begin
            mem_we = 1'b1;
            if (c_reg.kind == KIND_WRITE)
                mem_wd = {c_reg.red, c_reg.green, c_reg.blue};
            else if (c_reg.kind == KIND_SPLAT)
                mem_wd = {sr[8] ? 8'hFF : sr[7:0], sg[8] ? 8'hFF : sg[7:0],
                          sb[8] ? 8'hFF : sb[7:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[a_addr] <= mem_wd;
        rdata_reg <= mem[a_addr];
    end

    // neighbour in window for splat
    logic [10:0] nx, ny;
    logic        n_ok;
    assign nx   = {5'd0, c_reg.pos_x} + {10'd0, nb_reg[0]};
    assign ny   = {5'd0, c_reg.pos_y} + {10'd0, nb_reg[1]};
    assign n_ok = (nx < eff_w) && (ny < eff_h);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (clr_reg == DEPTH_C - 1'b1)
                    state_next = (c_reg.kind == KIND_CLEAR) ? S_DONE : S_IDLE;
                else
                    state_next = S_INIT;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    priority case (cmd.kind)
                        KIND_WRITE, KIND_READ, KIND_SHIFT: state_next = S_RD;
                        KIND_SPLAT: state_next = S_WGT;
                        KIND_CLEAR: state_next = S_INIT;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_WGT:   state_next = n_ok ? S_RD : ((nb_reg == 2'd3) ? S_DONE : S_WGT);
            S_RD:    state_next = (c_reg.kind == KIND_READ) ? S_DONE
                                : (c_reg.kind == KIND_SPLAT) ? S_MUL : S_WR;
            S_MUL:   state_next = S_WR;
            S_WR:
            begin
                if (c_reg.kind == KIND_SPLAT)
                    state_next = (nb_reg == 2'd3) ? S_DONE : S_WGT;
                else if (c_reg.kind == KIND_SHIFT)
                    state_next = (last_x && last_y) ? S_DONE : S_RD;
                else
                    state_next = S_DONE;
            end
            S_DONE:  state_next = (rq_cnt_reg != 2'd2) ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_take && cmd.kind == KIND_CLEAR)
                clr_reg <= '0;
            else if (clearing)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg <= '0;
        else if (cmd_take)
            c_reg <= cmd;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            nb_reg      <= 2'd0;
            res_rgb_reg <= 24'd0;
            res_st_reg  <= (cmd.kind == KIND_ERR);
            if (cmd.kind == KIND_SHIFT)
            begin
                x_reg <= (cmd.dir == DIR_RIGHT) ? eff_w - 11'd1 : 11'd0;
                y_reg <= (cmd.dir == DIR_DOWN)  ? eff_h - 11'd1 : 11'd0;
            end
            else
            begin
                x_reg <= {5'd0, cmd.pos_x};
                y_reg <= {5'd0, cmd.pos_y};
            end
            if (cmd.kind == KIND_SPLAT)
            begin
                wt_reg[0] <= wu(8'(9'd255 - {1'b0, cmd.frac_x}), 8'(9'd255 - {1'b0, cmd.frac_y}));
                wt_reg[1] <= wu(cmd.frac_x, 8'(9'd255 - {1'b0, cmd.frac_y}));
                wt_reg[2] <= wu(8'(9'd255 - {1'b0, cmd.frac_x}), cmd.frac_y);
                wt_reg[3] <= wu(cmd.frac_x, cmd.frac_y);
            end
        end
        else
        begin
            if (state_reg == S_WGT)
            begin
                x_reg <= nx;
                y_reg <= ny;
                if (!n_ok && nb_reg != 2'd3)
                    nb_reg <= nb_reg + 2'd1;
            end
            if (state_reg == S_MUL)
            begin
                pr_reg <= c_reg.red   * wsel;
                pg_reg <= c_reg.green * wsel;
                pb_reg <= c_reg.blue  * wsel;
            end
            if (state_reg == S_WR && c_reg.kind == KIND_SPLAT)
                nb_reg <= nb_reg + 2'd1;
            if (state_reg == S_WR && c_reg.kind == KIND_SHIFT)
            begin
                if (last_x)
                begin
                    x_reg <= x_first;
                    y_reg <= (c_reg.dir == DIR_DOWN) ? y_reg - 11'd1 : y_reg + 11'd1;
                end
                else
                    x_reg <= (c_reg.dir == DIR_RIGHT) ? x_reg - 11'd1 : x_reg + 11'd1;
            end
        end
    end

    // result on leaving DONE
    assign res_push = rq_cnt_reg != 2'd2 && (state_reg == S_DONE);

    logic [23:0] res_val;
    assign res_val = (c_reg.kind == KIND_READ) ? rdata_reg : res_rgb_reg;

    always_ff @(posedge clk)
    begin
        if (res_push)
            rq_reg[rq_wr_reg] <= {res_st_reg, res_val};
    end

    logic do_pop;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_rd_reg  <= 1'b0;
            rq_wr_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
                rq_wr_reg <= !rq_wr_reg;
            if (do_pop)
                rq_rd_reg <= !rq_rd_reg;
            rq_cnt_reg <= rq_cnt_reg + {1'b0, res_push} - {1'b0, do_pop};
        end
    end

    assign empty     = (rq_cnt_reg == 2'd0);
    assign status    = rq_reg[rq_rd_reg][24];
    assign red_out   = rq_reg[rq_rd_reg][23:16];
    assign green_out = rq_reg[rq_rd_reg][15:8];
    assign blue_out  = rq_reg[rq_rd_reg][7:0];

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE) else $error("take outside idle");
    a_rq_range: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg != 2'd3) else $error("result queue overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> rq_cnt_reg != 2'd2) else $error("push into full result queue");

endmodule
`default_nettype wire

// ----- sv/rgb_framebuffer_subpixel_plot.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_framebuffer_subpixel_plot
// RGB888 pixel store with write, read, subpixel splat, clear and shift.
// ---------------------------------------------------------------------------
// Commands run one at a time: errors and no-ops give a result without touching
// the memory, a splat does a read-modify-write for each neighbour in the window
// (up to four) on the single-port pixel memory, a shift moves one pixel per
// read and write, and clear zeroes the whole memory. The next command is taken once the back end is idle again.
// Reset: registers to 64; a clearing pass zeroes the memory, during which no
// command is executed.
module rgb_framebuffer_subpixel_plot
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  op,
    input  wire logic [5:0]  pos_x,
    input  wire logic [5:0]  pos_y,
    input  wire logic [7:0]  frac_x,
    input  wire logic [7:0]  frac_y,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic [5:0]  shift_amount,
    input  wire logic [1:0]  shift_dir,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic             status
);
    import rfsp_pkg::*;

    logic [6:0]  active_width_reg, active_height_reg;
    logic [10:0] eff_w, eff_h;
    logic        cmd_valid, cmd_take;
    cmd_t        cmd;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg  <= 7'd64;
            active_height_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == 3'd0)
                active_width_reg <= pwdata[6:0];
            else if (paddr == 3'd4)
                active_height_reg <= pwdata[6:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == 3'd0)
            prdata = {25'd0, active_width_reg};
        else if (paddr == 3'd4)
            prdata = {25'd0, active_height_reg};
    end

    always_comb
    begin
        if (active_width_reg == 7'd0)
            eff_w = 11'd1;
        else if ({4'd0, active_width_reg} > 11'(MAX_WIDTH))
            eff_w = 11'(MAX_WIDTH);
        else
            eff_w = {4'd0, active_width_reg};
        if (active_height_reg == 7'd0)
            eff_h = 11'd1;
        else if ({4'd0, active_height_reg} > 11'(MAX_HEIGHT))
            eff_h = 11'(MAX_HEIGHT);
        else
            eff_h = {4'd0, active_height_reg};
    end

    rfsp_front u_front
    (
        .clk, .rst_n, .push, .full, .op, .pos_x, .pos_y, .frac_x, .frac_y,
        .red_in, .green_in, .blue_in, .shift_amount, .shift_dir,
        .eff_w, .eff_h, .cmd_valid, .cmd, .cmd_take
    );

    rfsp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back
    (
        .clk, .rst_n, .eff_w, .eff_h, .cmd_valid, .cmd, .cmd_take,
        .empty, .pop, .red_out, .green_out, .blue_out, .status
    );

endmodule
`default_nettype wire
